// ===== hdl/dpam_pkg.sv =====
// Shared types and constants of the decimation pyramid.
`default_nettype none

package dpam_pkg;

	// Fixed field widths of the register file and of the result.
	localparam int LEVEL_W    = 4;
	localparam int CHAN_W     = 6;
	localparam int PPF_W      = 7;
	localparam int KEEP_W     = 16;
	localparam int FRAME_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PPF  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEEP = 2'd3;

	// Pair reduction modes.
	localparam logic MODE_AVG = 1'b0;
	localparam logic MODE_MAX = 1'b1;

	// Per-cycle control of one level cell.
	typedef struct packed {
		logic fire;   // cell handles the request at this level now
		logic load;   // take the sample handed over from the left
		logic rd;     // prefetch the pair entry of the new request
		logic store;  // first frame of a pair: keep the sample
		logic mode;   // pair reduction mode
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/dpam_in_if.sv =====
// Sample input channel.
`default_nettype none

interface dpam_in_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_value;

	modport source(output valid, output sample_value, input ready);
	modport sink(input valid, input sample_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/dpam_out_if.sv =====
// Result output channel.
`default_nettype none

interface dpam_out_if
	import dpam_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic [LEVEL_W-1:0]            level;
	logic [CHAN_W-1:0]             channel;
	logic signed [SAMPLE_BITS-1:0] value;
	logic signed [SAMPLE_BITS-1:0] level_min;
	logic signed [SAMPLE_BITS-1:0] level_max;
	logic                          last;

	modport source(output valid, output level, output channel, output value,
		output level_min, output level_max, output last, input ready);
	modport sink(input valid, input level, input channel, input value,
		input level_min, input level_max, input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/dpam_cell.sv =====
// One pyramid level: pair memory, running extremes and pair reduction.
`default_nettype none

module dpam_cell
	import dpam_pkg::*;
#(
	parameter int SAMPLE_BITS = 16,
	parameter int DEPTH = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cell_ctl_t                     ctl,
	input  logic [ADDR_W-1:0]             rd_addr,
	input  logic [ADDR_W-1:0]             wr_addr,
	input  logic signed [SAMPLE_BITS-1:0] v_in,
	output logic signed [SAMPLE_BITS-1:0] value,
	output logic signed [SAMPLE_BITS-1:0] pass,
	output logic signed [SAMPLE_BITS-1:0] res_min,
	output logic signed [SAMPLE_BITS-1:0] res_max
);

	localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
	logic signed [SAMPLE_BITS-1:0] v_q;
	logic signed [SAMPLE_BITS-1:0] rd_q;
	logic signed [SAMPLE_BITS-1:0] min_q;
	logic signed [SAMPLE_BITS-1:0] max_q;
	logic signed [SAMPLE_BITS:0]   sum;
	logic signed [SAMPLE_BITS-1:0] avg;
	logic signed [SAMPLE_BITS-1:0] mx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= SMAX;
			max_q <= SMIN;
		end else if (ctl.fire) begin
			min_q <= res_min;
			max_q <= res_max;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			v_q <= v_in;
		end
		if (ctl.rd) begin
			rd_q <= mem[rd_addr];
		end
		if (ctl.fire && ctl.store) begin
			mem[wr_addr] <= v_q;
		end
	end

	// floor average is the arithmetic shift of the widened sum
	assign sum     = {v_q[SAMPLE_BITS-1], v_q} + {rd_q[SAMPLE_BITS-1], rd_q};
	assign avg     = sum[SAMPLE_BITS:1];
	assign mx      = (rd_q > v_q) ? rd_q : v_q;
	assign pass    = (ctl.mode == MODE_MAX) ? mx : avg;
	assign value   = v_q;
	assign res_min = (v_q < min_q) ? v_q : min_q;
	assign res_max = (v_q > max_q) ? v_q : max_q;

endmodule

`default_nettype wire

// ===== hdl/decimation_pyramid_avg_max_core.sv =====
// Top level: dyadic decimation pyramid built as a row of level cells.
// Walk: a request is taken while idle; its walk then visits one level cell per
//   cycle, levels 0..S, where S is the lower of top_level and the pair-walk end level,
//   unless a result finds the output register full. No new request is taken until the walk ends.
// Reset: counters clear, running extremes go to the sample limits, registers to their
//   defaults; the pair memories are not cleared and need no clearing pass.
`default_nettype none

module decimation_pyramid_avg_max_core
	import dpam_pkg::*;
#(
	parameter int LEVELS = 16,
	parameter int CHANNELS = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	dpam_in_if.sink                 samples,
	dpam_out_if.source              results
);

	// Only the first sixteen levels ever receive data (top_level is four bits).
	localparam int NCELL = (LEVELS < 16) ? LEVELS : 16;
	// Channel positions reachable with a 7-bit frame length.
	localparam int CH_USED = (CHANNELS < 127) ? CHANNELS : 127;
	localparam int CH_W = (CH_USED > 1) ? $clog2(CH_USED) : 1;

	// ---------------- configuration registers ----------------
	logic [PPF_W-1:0]   ppf_q;
	logic [LEVEL_W-1:0] top_q;
	logic               mode_q;
	logic [KEEP_W-1:0]  keep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppf_q  <= PPF_W'(64);
			top_q  <= LEVEL_W'(15);
			mode_q <= MODE_AVG;
			keep_q <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PPF:  ppf_q  <= cfg_data[PPF_W-1:0];
				REG_TOP:  top_q  <= cfg_data[LEVEL_W-1:0];
				REG_MODE: mode_q <= cfg_data[0];
				REG_KEEP: keep_q <= cfg_data[KEEP_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- request bookkeeping ----------------
	logic                busy_q;
	logic [LEVEL_W-1:0]  pos_q;      // level cell handling the request now
	logic [LEVEL_W-1:0]  stop_q;     // last level the request reaches
	logic [KEEP_W-1:0]   rem_q;      // emitting levels still ahead, bit 0 = current
	logic [CH_W-1:0]     ch_item_q;  // channel of the request in flight
	logic [NCELL-1:0]    phase_q;    // pair phase per level for this request
	logic [CH_W-1:0]     ch_q;
	logic [FRAME_W-1:0]  f_q;

	logic                accept;
	logic [PPF_W-1:0]    ppf_eff;
	logic [7:0]          ppf8;
	logic [7:0]          ch8;
	logic [7:0]          nxt8;
	logic                wrap0;
	logic                wrap1;
	logic [CH_W-1:0]     ch_eff;
	logic [CH_W-1:0]     ch_nxt;
	logic [FRAME_W-1:0]  f_eff;
	logic [FRAME_W-1:0]  f_nxt;
	logic [LEVEL_W-1:0]  top_eff;
	logic [LEVEL_W:0]    run;
	logic [LEVEL_W-1:0]  stop;
	logic [KEEP_W-1:0]   emit_mask;

	logic                out_valid_q;
	logic                out_free;
	logic                cur_emit;
	logic                go;
	logic                done;

	assign samples.ready = !busy_q;
	assign accept = samples.valid && samples.ready;

	always_comb begin
		// frame length: zero acts as one, the channel count caps it
		if (ppf_q == '0) begin
			ppf_eff = PPF_W'(1);
		end else if ({4'b0, ppf_q} > 11'(CHANNELS)) begin
			ppf_eff = PPF_W'(CH_USED);
		end else begin
			ppf_eff = ppf_q;
		end
		ppf8 = {1'b0, ppf_eff};
		ch8  = {{(8-CH_W){1'b0}}, ch_q};

		// close a partial frame when the frame length shrank under us
		wrap0  = (ch8 >= ppf8);
		ch_eff = wrap0 ? '0 : ch_q;
		f_eff  = wrap0 ? f_q + 1'b1 : f_q;

		nxt8   = {{(8-CH_W){1'b0}}, ch_eff} + 8'd1;
		wrap1  = (nxt8 >= ppf8);
		ch_nxt = wrap1 ? '0 : nxt8[CH_W-1:0];
		f_nxt  = wrap1 ? f_eff + 1'b1 : f_eff;

		if ({2'b0, top_q} > 6'(NCELL - 1)) begin
			top_eff = LEVEL_W'(NCELL - 1);
		end else begin
			top_eff = top_q;
		end

		// the walk passes every level whose frame bit is one: trailing ones
		run = (LEVEL_W+1)'(FRAME_W);
		for (int i = FRAME_W - 1; i >= 0; i--) begin
			if (!f_eff[i]) begin
				run = (LEVEL_W+1)'(i);
			end
		end
		stop = ({1'b0, top_eff} < run) ? top_eff : run[LEVEL_W-1:0];

		for (int i = 0; i < KEEP_W; i++) begin
			emit_mask[i] = keep_q[i] && (LEVEL_W'(i) <= stop);
		end
	end

	// a level step proceeds unless its result finds the output register full
	assign cur_emit = rem_q[0];
	assign out_free = !out_valid_q || results.ready;
	assign go       = busy_q && (!cur_emit || out_free);
	assign done     = go && (pos_q == stop_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
			stop_q <= '0;
			rem_q  <= '0;
			ch_q   <= '0;
			f_q    <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
			stop_q <= stop;
			rem_q  <= emit_mask;
			ch_q   <= ch_nxt;
			f_q    <= f_nxt;
		end else if (go) begin
			if (done) begin
				busy_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 1'b1;
				rem_q <= rem_q >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_item_q <= ch_eff;
			phase_q   <= f_eff[NCELL-1:0];
		end
	end

	// ---------------- row of level cells ----------------
	logic signed [SAMPLE_BITS-1:0] value_w [NCELL];
	logic signed [SAMPLE_BITS-1:0] pass_w  [NCELL];
	logic signed [SAMPLE_BITS-1:0] min_w   [NCELL];
	logic signed [SAMPLE_BITS-1:0] max_w   [NCELL];
	logic [NCELL-1:0]              fire_w;

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		cell_ctl_t                     ctl;
		logic signed [SAMPLE_BITS-1:0] v_in;

		assign fire_w[k]  = go && (pos_q == LEVEL_W'(k));
		assign ctl.fire   = fire_w[k];
		assign ctl.rd     = accept;
		// the first frame of a pair is kept, except at the top level
		assign ctl.store  = !phase_q[k] && (LEVEL_W'(k) != top_eff);
		assign ctl.mode   = mode_q;

		if (k == 0) begin : g_head
			assign ctl.load = accept;
			assign v_in     = samples.sample_value;
		end else begin : g_link
			assign ctl.load = fire_w[k-1];
			assign v_in     = pass_w[k-1];
		end

		dpam_cell #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.DEPTH(CH_USED)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.rd_addr(ch_eff),
			.wr_addr(ch_item_q),
			.v_in(v_in),
			.value(value_w[k]),
			.pass(pass_w[k]),
			.res_min(min_w[k]),
			.res_max(max_w[k])
		);
	end

	// the active cell's result, picked by the walk position
	logic signed [SAMPLE_BITS-1:0] sel_value;
	logic signed [SAMPLE_BITS-1:0] sel_min;
	logic signed [SAMPLE_BITS-1:0] sel_max;

	always_comb begin
		sel_value = '0;
		sel_min   = '0;
		sel_max   = '0;
		for (int k = 0; k < NCELL; k++) begin
			if (pos_q == LEVEL_W'(k)) begin
				sel_value = sel_value | value_w[k];
				sel_min   = sel_min | min_w[k];
				sel_max   = sel_max | max_w[k];
			end
		end
	end

	// ---------------- output register ----------------
	logic [CH_W+CHAN_W-1:0]        chan_ext;
	logic [LEVEL_W-1:0]            level_q;
	logic [CHAN_W-1:0]             channel_q;
	logic signed [SAMPLE_BITS-1:0] value_q;
	logic signed [SAMPLE_BITS-1:0] min_q;
	logic signed [SAMPLE_BITS-1:0] max_q;
	logic                          last_q;

	assign chan_ext = {{CHAN_W{1'b0}}, ch_item_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && cur_emit) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && cur_emit) begin
			level_q   <= pos_q;
			channel_q <= chan_ext[CHAN_W-1:0];
			value_q   <= sel_value;
			min_q     <= sel_min;
			max_q     <= sel_max;
			// last when no emitting level remains further up the walk
			last_q    <= (rem_q[KEEP_W-1:1] == '0);
		end
	end

	assign results.valid     = out_valid_q;
	assign results.level     = level_q;
	assign results.channel   = channel_q;
	assign results.value     = value_q;
	assign results.level_min = min_q;
	assign results.level_max = max_q;
	assign results.last      = last_q;

endmodule

`default_nettype wire
